FILE: hdl/net_bounding_box_wirelength_defines.svh
`ifndef NET_BOUNDING_BOX_WIRELENGTH_DEFINES_SVH
`define NET_BOUNDING_BOX_WIRELENGTH_DEFINES_SVH

// same-cycle implication, checked outside reset
`define NBBW_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define NBBW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/nbbw_pkg.sv
`timescale 1ns / 1ps

package nbbw_pkg;

	localparam int COORD_BITS_DEF  = 32;
	localparam int COUNT_BITS_DEF  = 16;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam int PIN_BITS    = 32;
	localparam int CNT_BITS    = 16;
	localparam int COST_BITS   = 47;
	localparam int WEIGHT_BITS = 16;
	localparam int FRAC_BITS   = 8;
	localparam int PROD_BITS   = PIN_BITS + WEIGHT_BITS;
	localparam int SUM_BITS    = COST_BITS + 1;

	localparam logic [WEIGHT_BITS-1:0] WEIGHT_RESET = WEIGHT_BITS'(256);

	typedef struct packed {
		logic signed [PIN_BITS-1:0] pin_x;
		logic signed [PIN_BITS-1:0] pin_y;
		logic                       first_pin;
		logic                       last_pin;
		logic                       net_ignored;
		logic                       restart_total;
	} pin_req_t;

	typedef struct packed {
		logic [PIN_BITS-1:0]  half_width;
		logic [PIN_BITS-1:0]  half_height;
		logic [CNT_BITS-1:0]  left_count;
		logic [CNT_BITS-1:0]  right_count;
		logic [CNT_BITS-1:0]  bottom_count;
		logic [CNT_BITS-1:0]  top_count;
		logic [CNT_BITS-1:0]  pin_total;
		logic [COST_BITS-1:0] total_cost;
	} res_req_t;

	// finished net handed from front to back
	typedef struct packed {
		logic [PIN_BITS-1:0] half_width;
		logic [PIN_BITS-1:0] half_height;
		logic [CNT_BITS-1:0] left_count;
		logic [CNT_BITS-1:0] right_count;
		logic [CNT_BITS-1:0] bottom_count;
		logic [CNT_BITS-1:0] top_count;
		logic [CNT_BITS-1:0] pin_total;
		logic                restart;
	} net_rec_t;

endpackage

FILE: hdl/nbbw_front.sv
`timescale 1ns / 1ps

module nbbw_front #(
	parameter int COORD_BITS = nbbw_pkg::COORD_BITS_DEF,
	parameter int COUNT_BITS = nbbw_pkg::COUNT_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  nbbw_pkg::pin_req_t in_req,
	input  logic               full,
	output logic               push,
	output nbbw_pkg::net_rec_t push_rec
);

	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
	localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

	logic signed [COORD_BITS-1:0] lo_q [2];
	logic signed [COORD_BITS-1:0] hi_q [2];
	logic signed [COORD_BITS-1:0] lo_n [2];
	logic signed [COORD_BITS-1:0] hi_n [2];
	logic signed [COORD_BITS-1:0] v    [2];
	logic [COUNT_BITS-1:0]        cnt_q [4];
	logic [COUNT_BITS-1:0]        cnt_n [4];
	logic [COUNT_BITS-1:0]        pins_q;
	logic [COUNT_BITS-1:0]        pins_n;
	logic                         pend_q;
	logic                         accept;
	logic                         emit;
	logic                         restart_n;
	logic [COORD_BITS-1:0]        w_d;
	logic [COORD_BITS-1:0]        h_d;

	function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] c);
		bump = (c == CNT_MAX) ? c : c + CNT_ONE;
	endfunction

	assign in_stall  = full;
	assign accept    = in_valid && !full;
	assign emit      = accept && in_req.last_pin && !in_req.net_ignored;
	assign restart_n = in_req.restart_total || pend_q;

	assign v[0] = in_req.pin_x[COORD_BITS-1:0];
	assign v[1] = in_req.pin_y[COORD_BITS-1:0];

	always_comb begin
		for (int a = 0; a < 2; a++) begin
			lo_n[a]       = lo_q[a];
			hi_n[a]       = hi_q[a];
			cnt_n[2*a]    = cnt_q[2*a];
			cnt_n[2*a+1]  = cnt_q[2*a+1];
			if (in_req.first_pin) begin
				lo_n[a]      = v[a];
				hi_n[a]      = v[a];
				cnt_n[2*a]   = CNT_ONE;
				cnt_n[2*a+1] = CNT_ONE;
			end else if (v[a] < lo_q[a]) begin
				lo_n[a]    = v[a];
				cnt_n[2*a] = CNT_ONE;
			end else if (v[a] == lo_q[a]) begin
				cnt_n[2*a] = bump(cnt_q[2*a]);
				if (v[a] == hi_q[a]) begin
					cnt_n[2*a+1] = bump(cnt_q[2*a+1]);
				end
			end else if (v[a] > hi_q[a]) begin
				hi_n[a]      = v[a];
				cnt_n[2*a+1] = CNT_ONE;
			end else if (v[a] == hi_q[a]) begin
				cnt_n[2*a+1] = bump(cnt_q[2*a+1]);
			end
		end
		pins_n = in_req.first_pin ? CNT_ONE : bump(pins_q);
	end

	assign w_d = COORD_BITS'(hi_n[0] - lo_n[0]);
	assign h_d = COORD_BITS'(hi_n[1] - lo_n[1]);

	assign push                  = emit;
	assign push_rec.half_width   = nbbw_pkg::PIN_BITS'(w_d);
	assign push_rec.half_height  = nbbw_pkg::PIN_BITS'(h_d);
	assign push_rec.left_count   = nbbw_pkg::CNT_BITS'(cnt_n[0]);
	assign push_rec.right_count  = nbbw_pkg::CNT_BITS'(cnt_n[1]);
	assign push_rec.bottom_count = nbbw_pkg::CNT_BITS'(cnt_n[2]);
	assign push_rec.top_count    = nbbw_pkg::CNT_BITS'(cnt_n[3]);
	assign push_rec.pin_total    = nbbw_pkg::CNT_BITS'(pins_n);
	assign push_rec.restart      = restart_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 2; a++) begin
				lo_q[a] <= '0;
				hi_q[a] <= '0;
			end
			for (int k = 0; k < 4; k++) begin
				cnt_q[k] <= '0;
			end
			pins_q <= '0;
			pend_q <= 1'b0;
		end else if (accept) begin
			for (int a = 0; a < 2; a++) begin
				lo_q[a] <= lo_n[a];
				hi_q[a] <= hi_n[a];
			end
			for (int k = 0; k < 4; k++) begin
				cnt_q[k] <= cnt_n[k];
			end
			pins_q <= pins_n;
			// a restart on a pin that emits nothing waits for the next emitted net
			pend_q <= emit ? 1'b0 : restart_n;
		end
	end

endmodule

FILE: hdl/nbbw_queue.sv
`timescale 1ns / 1ps

module nbbw_queue #(
	parameter int DEPTH = nbbw_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  nbbw_pkg::net_rec_t push_rec,
	output logic               full,
	input  logic               pop,
	output logic               rec_valid,
	output nbbw_pkg::net_rec_t rec
);

	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W    = $clog2(DEPTH + 1);
	localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
	localparam logic [PTR_BITS-1:0] PTR_ONE  = PTR_BITS'(1);
	localparam logic [CNT_W-1:0]    FULL_CNT = CNT_W'(DEPTH);
	localparam logic [CNT_W-1:0]    CNT_ONE  = CNT_W'(1);

	nbbw_pkg::net_rec_t      q_q [DEPTH];
	logic [PTR_BITS-1:0]     wr_q;
	logic [PTR_BITS-1:0]     rd_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    do_push;
	logic                    do_pop;

	assign full      = (cnt_q == FULL_CNT);
	assign rec_valid = (cnt_q != '0);
	assign rec       = q_q[rd_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && rec_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			q_q[wr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + PTR_ONE;
			end
			if (do_pop) begin
				rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + PTR_ONE;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + CNT_ONE;
				2'b01:   cnt_q <= cnt_q - CNT_ONE;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: hdl/nbbw_back.sv
`timescale 1ns / 1ps

module nbbw_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [nbbw_pkg::WEIGHT_BITS-1:0]     weight,
	input  logic                                 rec_valid,
	input  nbbw_pkg::net_rec_t                   rec,
	output logic                                 pop,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output nbbw_pkg::res_req_t                   out_req
);

	localparam logic [nbbw_pkg::SUM_BITS-1:0] COST_MAX =
		nbbw_pkg::SUM_BITS'((48'd1 << nbbw_pkg::COST_BITS) - 48'd1);

	logic                                valid_s1;
	nbbw_pkg::net_rec_t                  rec_s1;
	logic [nbbw_pkg::PROD_BITS-1:0]      prod_s1;
	logic [nbbw_pkg::PROD_BITS-1:0]      prod_d;
	logic                                valid_s2;
	nbbw_pkg::res_req_t                  res_s2;
	logic [nbbw_pkg::COST_BITS-1:0]      cost_q;
	logic                                en2;
	logic                                adv1;
	logic [nbbw_pkg::SUM_BITS-1:0]       base_d;
	logic [nbbw_pkg::SUM_BITS-1:0]       add_d;
	logic [nbbw_pkg::SUM_BITS-1:0]       sum_d;
	logic [nbbw_pkg::COST_BITS-1:0]      total_d;

	assign en2  = !valid_s2 || !out_stall;
	assign adv1 = !valid_s1 || en2;
	assign pop  = rec_valid && adv1;

	assign prod_d = rec.half_height * weight;

	assign base_d  = rec_s1.restart ? '0 : nbbw_pkg::SUM_BITS'(cost_q);
	assign add_d   = nbbw_pkg::SUM_BITS'(rec_s1.half_width)
		+ nbbw_pkg::SUM_BITS'(prod_s1 >> nbbw_pkg::FRAC_BITS);
	assign sum_d   = base_d + add_d;
	assign total_d = (sum_d > COST_MAX) ? COST_MAX[nbbw_pkg::COST_BITS-1:0]
		: sum_d[nbbw_pkg::COST_BITS-1:0];

	always_ff @(posedge clk) begin
		if (pop) begin
			rec_s1  <= rec;
			prod_s1 <= prod_d;
		end
		if (valid_s1 && en2) begin
			res_s2.half_width   <= rec_s1.half_width;
			res_s2.half_height  <= rec_s1.half_height;
			res_s2.left_count   <= rec_s1.left_count;
			res_s2.right_count  <= rec_s1.right_count;
			res_s2.bottom_count <= rec_s1.bottom_count;
			res_s2.top_count    <= rec_s1.top_count;
			res_s2.pin_total    <= rec_s1.pin_total;
			res_s2.total_cost   <= total_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			cost_q   <= '0;
		end else begin
			if (adv1) begin
				valid_s1 <= rec_valid;
			end
			if (en2) begin
				valid_s2 <= valid_s1;
			end
			if (valid_s1 && en2) begin
				cost_q <= total_d;
			end
		end
	end

	assign out_valid = valid_s2;
	assign out_req   = res_s2;

endmodule

FILE: hdl/net_bounding_box_wirelength.sv
`timescale 1ns / 1ps
// net bounding box wirelength, one pin per cycle while the queue is not full
// a net's result passes through the queue and then the back's product and result registers
// throughput: one pin per cycle unless stalled, set by the front's box compare and update
// the back multiplies and accumulates one net per cycle unless stalled, behind a small queue
// reset (async, active low): box, counts and total cleared, weight 1.0, queue empty

module net_bounding_box_wirelength #(
	parameter int COORD_BITS  = nbbw_pkg::COORD_BITS_DEF,
	parameter int COUNT_BITS  = nbbw_pkg::COUNT_BITS_DEF,
	parameter int QUEUE_DEPTH = nbbw_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  nbbw_pkg::pin_req_t               in_req,
	output logic                             out_valid,
	input  logic                             out_stall,
	output nbbw_pkg::res_req_t               out_req,
	input  logic                             cfg_we,
	input  logic [nbbw_pkg::WEIGHT_BITS-1:0] cfg_data
);

	logic [nbbw_pkg::WEIGHT_BITS-1:0] weight_q;
	logic                             full;
	logic                             push;
	nbbw_pkg::net_rec_t               push_rec;
	logic                             pop;
	logic                             rec_valid;
	nbbw_pkg::net_rec_t               rec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= nbbw_pkg::WEIGHT_RESET;
		end else if (cfg_we) begin
			weight_q <= cfg_data;
		end
	end

	nbbw_front #(
		.COORD_BITS (COORD_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_req   (in_req),
		.full     (full),
		.push     (push),
		.push_rec (push_rec)
	);

	nbbw_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_rec  (push_rec),
		.full      (full),
		.pop       (pop),
		.rec_valid (rec_valid),
		.rec       (rec)
	);

	nbbw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.weight    (weight_q),
		.rec_valid (rec_valid),
		.rec       (rec),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_req   (out_req)
	);

endmodule

FILE: hdl/nbbw_checker.sv
`timescale 1ns / 1ps
`include "net_bounding_box_wirelength_defines.svh"

module nbbw_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input nbbw_pkg::res_req_t out_req
);

	`NBBW_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(out_req), "stalled request changed or dropped")

	`NBBW_ASSERT_NEXT(a_drain, clk, arst_n, !out_stall,
		!in_stall, "input stalled although the result side is draining")

	`NBBW_ASSERT_NOW(a_cost_floor, clk, arst_n, out_valid,
		{15'd0, out_req.half_width} <= out_req.total_cost,
		"total cost below the width of the net just added")

endmodule

bind net_bounding_box_wirelength nbbw_checker u_nbbw_checker (.*);

FILE: sim/tb_net_bounding_box_wirelength.sv
`timescale 1ns / 1ps

module tb_net_bounding_box_wirelength;
	import nbbw_pkg::*;

	typedef longint unsigned u64_t;
	typedef enum int {LEFT_EDGE, RIGHT_EDGE, BOTTOM_EDGE, TOP_EDGE} box_side_e;

	localparam int X_AXIS = 0;
	localparam int Y_AXIS = 1;
	localparam int SEND_SIDE = 0;
	localparam int RECV_SIDE = 1;
	localparam int NEAR_COORDS = 0;
	localparam int WIDE_COORDS = 1;
	localparam int EDGE_COORDS = 2;
	localparam int DRAIN_CYCLES = 4;
	localparam int LONG_HOLD = 250;
	localparam u64_t COST_TOP = (64'd1 << COST_BITS) - 1;
	localparam u64_t CNT_TOP = (64'd1 << COUNT_BITS_DEF) - 1;
	localparam logic [PIN_BITS-1:0] PIN_MIN = 32'h8000_0000;
	localparam logic [PIN_BITS-1:0] PIN_MAX = 32'h7fff_ffff;

	class hpwl_scoreboard;
		longint lo [2];
		longint hi [2];
		u64_t side_cnt [4];
		u64_t pins;
		u64_t cost;
		u64_t weight;
		res_req_t nets_due [$];
		int errors;

		function new();
			weight = WEIGHT_RESET;
		endfunction

		function void set_weight(logic [WEIGHT_BITS-1:0] w);
			weight = w;
		endfunction

		function u64_t bump(u64_t c);
			return (c >= CNT_TOP) ? CNT_TOP : c + 1;
		endfunction

		// tie rule: a pin on the low edge also counts high when the box is flat
		function void step_axis(int ax, longint v, int lo_side, int hi_side);
			if (v < lo[ax]) begin
				lo[ax] = v;
				side_cnt[lo_side] = 1;
			end else if (v == lo[ax]) begin
				side_cnt[lo_side] = bump(side_cnt[lo_side]);
				if (v == hi[ax])
					side_cnt[hi_side] = bump(side_cnt[hi_side]);
			end else if (v > hi[ax]) begin
				hi[ax] = v;
				side_cnt[hi_side] = 1;
			end else if (v == hi[ax]) begin
				side_cnt[hi_side] = bump(side_cnt[hi_side]);
			end
		endfunction

		function void note_pin(pin_req_t p);
			longint x;
			longint y;
			u64_t w;
			u64_t h;
			u64_t add;
			res_req_t net;
			x = longint'($signed(p.pin_x));
			y = longint'($signed(p.pin_y));
			if (p.restart_total)
				cost = 0;
			if (p.first_pin) begin
				lo[X_AXIS] = x;
				hi[X_AXIS] = x;
				lo[Y_AXIS] = y;
				hi[Y_AXIS] = y;
				foreach (side_cnt[i])
					side_cnt[i] = 1;
				pins = 1;
			end else begin
				step_axis(X_AXIS, x, LEFT_EDGE, RIGHT_EDGE);
				step_axis(Y_AXIS, y, BOTTOM_EDGE, TOP_EDGE);
				pins = bump(pins);
			end
			if (!p.last_pin || p.net_ignored)
				return;
			w = (hi[X_AXIS] >= lo[X_AXIS]) ? u64_t'(hi[X_AXIS] - lo[X_AXIS]) : 0;
			h = (hi[Y_AXIS] >= lo[Y_AXIS]) ? u64_t'(hi[Y_AXIS] - lo[Y_AXIS]) : 0;
			w &= 64'hFFFF_FFFF;
			h &= 64'hFFFF_FFFF;
			add = w + ((h * weight) >> FRAC_BITS);
			if (add > COST_TOP - cost)
				cost = COST_TOP;
			else
				cost += add;
			net.half_width = w[PIN_BITS-1:0];
			net.half_height = h[PIN_BITS-1:0];
			net.left_count = side_cnt[LEFT_EDGE][CNT_BITS-1:0];
			net.right_count = side_cnt[RIGHT_EDGE][CNT_BITS-1:0];
			net.bottom_count = side_cnt[BOTTOM_EDGE][CNT_BITS-1:0];
			net.top_count = side_cnt[TOP_EDGE][CNT_BITS-1:0];
			net.pin_total = pins[CNT_BITS-1:0];
			net.total_cost = cost[COST_BITS-1:0];
			nets_due.push_back(net);
		endfunction

		function void cmp_field(string name, u64_t want, logic [63:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, actual %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_net(res_req_t got);
			res_req_t want;
			if (nets_due.size() == 0) begin
				$error("net result with no net pending");
				errors++;
				return;
			end
			want = nets_due.pop_front();
			cmp_field("half_width", want.half_width, got.half_width);
			cmp_field("half_height", want.half_height, got.half_height);
			cmp_field("left_count", want.left_count, got.left_count);
			cmp_field("right_count", want.right_count, got.right_count);
			cmp_field("bottom_count", want.bottom_count, got.bottom_count);
			cmp_field("top_count", want.top_count, got.top_count);
			cmp_field("pin_total", want.pin_total, got.pin_total);
			cmp_field("total_cost", want.total_cost, got.total_cost);
		endfunction

		function int waiting();
			return nets_due.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	pin_req_t in_req;
	logic out_valid;
	logic out_stall;
	res_req_t out_req;
	logic cfg_we;
	logic [WEIGHT_BITS-1:0] cfg_data;

	hpwl_scoreboard sb = new();
	int burst_left [2] = '{0, 0};
	int pins_sent = 0;
	int nets_taken = 0;
	bit no_gap = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	net_bounding_box_wirelength dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_req(in_req),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_req(out_req),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	// idle cycles before the next request, with runs of back-to-back traffic
	function automatic int pick_wait(int side);
		if (burst_left[side] > 0) begin
			burst_left[side]--;
			return 0;
		end
		if ($urandom_range(0, 49) == 0) begin
			burst_left[side] = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 9);
	endfunction

	function automatic pin_req_t mk_pin(logic [PIN_BITS-1:0] x, logic [PIN_BITS-1:0] y,
			bit first, bit last, bit ign, bit restart);
		pin_req_t p;
		p.pin_x = x;
		p.pin_y = y;
		p.first_pin = first;
		p.last_pin = last;
		p.net_ignored = ign;
		p.restart_total = restart;
		return p;
	endfunction

	function automatic logic [PIN_BITS-1:0] rand_coord(int mode);
		case (mode)
			NEAR_COORDS: return PIN_BITS'($urandom_range(0, 16)) - PIN_BITS'(8);
			WIDE_COORDS: return $urandom();
			default: begin
				case ($urandom_range(0, 4))
					0: return PIN_MIN;
					1: return PIN_MAX;
					2: return '0;
					3: return '1;
					default: return $urandom();
				endcase
			end
		endcase
	endfunction

	// enters and leaves at a falling edge
	task automatic send_pin(pin_req_t p);
		int gap;
		gap = no_gap ? 0 : pick_wait(SEND_SIDE);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_req = p;
		in_valid = 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_pin(p);
		pins_sent++;
		@(negedge clk);
	endtask

	task automatic settle();
		in_valid = 1'b0;
		while (sb.waiting() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_weight(logic [WEIGHT_BITS-1:0] w);
		cfg_data = w;
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.set_weight(w);
	endtask

	// mostly well-formed nets, some stray pins and nets missing their first mark
	task automatic random_pins(int goal);
		int start;
		int n;
		int mode;
		bit drop_first;
		start = pins_sent;
		while (pins_sent - start < goal) begin
			if ($urandom_range(0, 9) == 0) begin
				send_pin(mk_pin(rand_coord(WIDE_COORDS), rand_coord(EDGE_COORDS),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
			end else begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
				mode = $urandom_range(NEAR_COORDS, EDGE_COORDS);
				drop_first = ($urandom_range(0, 19) == 0);
				for (int i = 0; i < n; i++)
					send_pin(mk_pin(rand_coord(mode), rand_coord(mode),
						(i == 0) && !drop_first, i == n - 1,
						(i == n - 1) ? ($urandom_range(0, 9) == 0) : 1'($urandom_range(0, 1)),
						$urandom_range(0, 19) == 0));
			end
		end
	endtask

	// receiver: random stall after each result, two long hold-offs
	initial begin
		int hold;
		hold = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				sb.check_net(out_req);
				nets_taken++;
				if (nets_taken == 60 || nets_taken == 250)
					hold = LONG_HOLD;
				else
					hold = pick_wait(RECV_SIDE);
			end
			@(negedge clk);
			if (hold > 0) begin
				out_stall = 1'b1;
				hold--;
			end else begin
				out_stall = 1'b0;
			end
		end
	end

	initial begin
		in_valid = 1'b0;
		in_req = '0;
		cfg_we = 1'b0;
		cfg_data = WEIGHT_RESET;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// continuing pins straight after reset use the cleared box
		send_pin(mk_pin(5, -3, 0, 0, 0, 0));
		send_pin(mk_pin(0, 0, 0, 1, 0, 0));
		send_pin(mk_pin(PIN_MAX, PIN_MIN, 1, 1, 0, 0));
		send_pin(mk_pin(PIN_MIN, PIN_MAX, 1, 0, 0, 0));
		send_pin(mk_pin(PIN_MAX, PIN_MIN, 0, 1, 0, 0));
		// edge ties and count resets
		send_pin(mk_pin(10, 10, 1, 0, 0, 0));
		send_pin(mk_pin(10, 10, 0, 0, 0, 0));
		send_pin(mk_pin(5, 20, 0, 0, 0, 0));
		send_pin(mk_pin(5, 20, 0, 0, 0, 0));
		send_pin(mk_pin(7, 15, 0, 0, 1, 0));
		send_pin(mk_pin(20, 5, 0, 1, 0, 0));
		// ignored net with restart, then restarts on normal pins
		send_pin(mk_pin(1, 1, 1, 0, 0, 0));
		send_pin(mk_pin(100, -100, 0, 1, 1, 1));
		send_pin(mk_pin(0, 0, 1, 0, 0, 0));
		send_pin(mk_pin(3, 4, 0, 1, 0, 1));
		send_pin(mk_pin(-2, -2, 1, 0, 0, 0));
		send_pin(mk_pin(-2, -2, 0, 0, 0, 1));
		send_pin(mk_pin(2, 2, 0, 1, 0, 0));
		send_pin(mk_pin(-1, -1, 1, 1, 1, 1));
		send_pin(mk_pin(-1, 0, 1, 1, 0, 0));
		send_pin(mk_pin(0, -1, 0, 0, 0, 0));
		send_pin(mk_pin(-5, 3, 0, 1, 0, 0));
		settle();

		write_weight('0);
		random_pins(120);
		settle();

		// full-span nets at top weight drive the total into saturation
		write_weight('1);
		repeat (140) begin
			send_pin(mk_pin(PIN_MIN, PIN_MIN, 1, 0, 0, 0));
			send_pin(mk_pin(PIN_MAX, PIN_MAX, 0, 1, 0, 0));
		end
		send_pin(mk_pin(0, 0, 1, 0, 0, 1));
		send_pin(mk_pin(9, 9, 0, 1, 0, 0));
		random_pins(80);
		settle();

		repeat (3) begin
			write_weight(WEIGHT_BITS'($urandom_range(1, 65534)));
			random_pins(90);
			settle();
		end

		// one long net sent back to back
		write_weight(WEIGHT_RESET);
		no_gap = 1'b1;
		send_pin(mk_pin(3, -3, 1, 0, 0, 0));
		repeat (60) send_pin(mk_pin(3, -3, 0, 0, 0, 0));
		send_pin(mk_pin(3, -3, 0, 1, 0, 0));
		no_gap = 1'b0;
		random_pins(40);
		settle();

		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#1_000_000;
		$display("status: fail");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/nbbw_pkg.sv
hdl/nbbw_front.sv
hdl/nbbw_queue.sv
hdl/nbbw_back.sv
hdl/net_bounding_box_wirelength.sv
hdl/nbbw_checker.sv
sim/tb_net_bounding_box_wirelength.sv
